// ===== hdl/assert_macros.svh =====
// assertion macros for the top-level rtl file
// no dependencies; empty bodies when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed: a |-> c");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed: a |=> c");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif

`endif

// ===== hdl/tmss_pkg.sv =====
// types, codes and constants of the tile map store with scroll refresh
// no dependencies
package tmss_pkg;

  localparam int MAX_DIM     = 128;
  localparam int COORD_W     = $clog2(MAX_DIM);
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int TILE_W      = 8;
  localparam int PIX_W       = 16;
  localparam int SCR_W       = 5;
  localparam int LOG_W       = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int VIEW_COLS_DEF = 21;
  localparam int VIEW_ROWS_DEF = 15;
  localparam logic [PIX_W-1:0] SCROLL_BIAS = 16'd16;
  localparam logic [LOG_W-1:0] LOG_RESET   = 3'd7;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_READ   = 2'd1,
    CMD_FILL   = 2'd2,
    CMD_SCROLL = 2'd3
  } tmss_cmd_t;

  typedef enum logic [1:0] {
    KIND_DRAW = 2'd0,
    KIND_READ = 2'd1,
    KIND_SREG = 2'd2,
    KIND_DONE = 2'd3
  } tmss_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_LOG2  = 1'd0,
    REG_HEIGHT_LOG2 = 1'd1
  } tmss_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET,
    ST_FILL,
    ST_DONE_OUT,
    ST_READ,
    ST_READ_OUT,
    ST_SCROLL,
    ST_COL_RD,
    ST_COL_OUT,
    ST_ROW_CHECK,
    ST_ROW_RD,
    ST_ROW_OUT,
    ST_SREG_OUT
  } tmss_state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [PIX_W-1:0]   x;
    logic [PIX_W-1:0]   y;
    logic [COORD_W-1:0] x_other;
    logic [COORD_W-1:0] y_other;
    logic [TILE_W-1:0]  value;
  } tmss_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SCR_W-1:0]  screen_col;
    logic [SCR_W-1:0]  screen_row;
    logic [TILE_W-1:0] tile;
    logic [PIX_W-1:0]  hscroll;
    logic [PIX_W-1:0]  vscroll;
    logic              last;
  } tmss_result_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       latch;
    logic       mem_we;
    logic       mem_re;
    logic       fill_step;
    logic       col_setup;
    logic       col_step;
    logic       row_setup;
    logic       row_step;
    logic       commit;
    logic       out_load;
    tmss_kind_t out_kind;
    logic       out_last;
  } tmss_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic col_chg;
    logic row_chg;
    logic fill_end;
    logic col_end;
    logic row_end;
    logic out_free;
  } tmss_sts_t;

endpackage

// ===== hdl/tmss_if.sv =====
// valid/ready channel interfaces for items and results
// depends on tmss_pkg
interface tmss_in_if import tmss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [PIX_W-1:0]   x;
  logic [PIX_W-1:0]   y;
  logic [COORD_W-1:0] x_other;
  logic [COORD_W-1:0] y_other;
  logic [TILE_W-1:0]  value;

  modport source (output valid, cmd, x, y, x_other, y_other, value, input ready);
  modport sink   (input valid, cmd, x, y, x_other, y_other, value, output ready);
endinterface

interface tmss_out_if import tmss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [SCR_W-1:0]  screen_col;
  logic [SCR_W-1:0]  screen_row;
  logic [TILE_W-1:0] tile;
  logic [PIX_W-1:0]  hscroll;
  logic [PIX_W-1:0]  vscroll;
  logic              last;

  modport source (output valid, kind, screen_col, screen_row, tile, hscroll, vscroll, last,
                  input ready);
  modport sink   (input valid, kind, screen_col, screen_row, tile, hscroll, vscroll, last,
                  output ready);
endinterface

// ===== hdl/tmss_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module tmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/tmss_ctrl.sv =====
// command sequencer: walks each item through its cycles
// depends on tmss_pkg
module tmss_ctrl import tmss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_cmd,
  output logic      in_ready,
  input  tmss_sts_t sts,
  output tmss_ctl_t ctl
);

  tmss_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (tmss_cmd_t'(in_cmd))
            CMD_SET:    state_nxt = ST_SET;
            CMD_READ:   state_nxt = ST_READ;
            CMD_FILL:   state_nxt = ST_FILL;
            CMD_SCROLL: state_nxt = ST_SCROLL;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SET:      state_nxt = ST_DONE_OUT;
      ST_FILL:     if (sts.fill_end) state_nxt = ST_DONE_OUT;
      ST_DONE_OUT: if (sts.out_free) state_nxt = ST_IDLE;
      ST_READ:     state_nxt = ST_READ_OUT;
      ST_READ_OUT: if (sts.out_free) state_nxt = ST_IDLE;
      ST_SCROLL: begin
        priority if (sts.col_chg) state_nxt = ST_COL_RD;
        else if (sts.row_chg)     state_nxt = ST_ROW_RD;
        else                      state_nxt = ST_SREG_OUT;
      end
      ST_COL_RD:   state_nxt = ST_COL_OUT;
      ST_COL_OUT: begin
        if (sts.out_free) state_nxt = sts.col_end ? ST_ROW_CHECK : ST_COL_RD;
      end
      ST_ROW_CHECK: state_nxt = sts.row_chg ? ST_ROW_RD : ST_SREG_OUT;
      ST_ROW_RD:   state_nxt = ST_ROW_OUT;
      ST_ROW_OUT: begin
        if (sts.out_free) state_nxt = sts.row_end ? ST_SREG_OUT : ST_ROW_RD;
      end
      ST_SREG_OUT: if (sts.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl          = '0;
    ctl.out_kind = KIND_DONE;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctl.latch = in_valid;
      end
      ST_SET:  ctl.mem_we = 1'b1;
      ST_FILL: begin
        ctl.mem_we    = 1'b1;
        ctl.fill_step = 1'b1;
      end
      ST_DONE_OUT: begin
        ctl.out_load = sts.out_free;
        ctl.out_kind = KIND_DONE;
        ctl.out_last = 1'b1;
      end
      ST_READ: ctl.mem_re = 1'b1;
      ST_READ_OUT: begin
        ctl.out_load = sts.out_free;
        ctl.out_kind = KIND_READ;
        ctl.out_last = 1'b1;
      end
      ST_SCROLL: begin
        priority if (sts.col_chg) ctl.col_setup = 1'b1;
        else if (sts.row_chg)     ctl.row_setup = 1'b1;
        else                      ctl.row_setup = 1'b0;
      end
      ST_COL_RD: ctl.mem_re = 1'b1;
      ST_COL_OUT: begin
        ctl.out_load = sts.out_free;
        ctl.col_step = sts.out_free;
        ctl.out_kind = KIND_DRAW;
      end
      ST_ROW_CHECK: ctl.row_setup = sts.row_chg;
      ST_ROW_RD: ctl.mem_re = 1'b1;
      ST_ROW_OUT: begin
        ctl.out_load = sts.out_free;
        ctl.row_step = sts.out_free;
        ctl.out_kind = KIND_DRAW;
      end
      ST_SREG_OUT: begin
        ctl.out_load = sts.out_free;
        ctl.commit   = sts.out_free;
        ctl.out_kind = KIND_SREG;
        ctl.out_last = 1'b1;
      end
      default: in_ready = 1'b0;
    endcase
  end

endmodule

// ===== hdl/tmss_dp.sv =====
// datapath: config registers, cell cursor, scroll position, map store, result register
// depends on tmss_pkg and tmss_ram
module tmss_dp import tmss_pkg::*; #(
  parameter int VIEW_COLS = VIEW_COLS_DEF,
  parameter int VIEW_ROWS = VIEW_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LOG_W-1:0]     cfg_data,
  input  tmss_item_t           item,
  input  tmss_ctl_t            ctl,
  output tmss_sts_t            sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output tmss_result_t         result
);

  localparam int VIEW_MAX = (VIEW_COLS > VIEW_ROWS) ? VIEW_COLS : VIEW_ROWS;
  localparam int CNT_W    = $clog2(VIEW_MAX + 1);

  logic [LOG_W-1:0]   wl_r, hl_r;
  logic [COORD_W-1:0] wm, hm;
  logic [PIX_W-1:0]   px_r, py_r;
  logic [TILE_W-1:0]  val_r;
  logic [COORD_W-1:0] c_r, r_r, c0_r, c1_r, r1_r;
  logic [COORD_W-1:0] scol_r, srow_r, oc_r, or_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;
  tmss_result_t       res_r, res_nxt;

  logic [COORD_W-1:0] x1, x2, y1, y2, fc0, fc1, fr0, fr1, scol, srow;
  logic [PIX_W-1:0]   xsub, ysub;
  logic [ADDR_W-1:0]  addr;
  logic [TILE_W-1:0]  rdata;
  logic               adv_c, adv_r;
  logic [COORD_W-1:0] col_edge, row_edge;

  // map size masks
  assign wm = COORD_W'((8'd1 << wl_r) - 8'd1);
  assign hm = COORD_W'((8'd1 << hl_r) - 8'd1);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= LOG_RESET;
      hl_r <= LOG_RESET;
    end else if (cfg_we) begin
      unique case (tmss_reg_t'(cfg_index))
        REG_WIDTH_LOG2:  wl_r <= cfg_data;
        REG_HEIGHT_LOG2: hl_r <= cfg_data;
        default:         wl_r <= wl_r;
      endcase
    end
  end

  // fill rectangle corners, sorted
  assign x1  = item.x[COORD_W-1:0] & wm;
  assign x2  = item.x_other & wm;
  assign y1  = item.y[COORD_W-1:0] & hm;
  assign y2  = item.y_other & hm;
  assign fc0 = (x1 < x2) ? x1 : x2;
  assign fc1 = (x1 < x2) ? x2 : x1;
  assign fr0 = (y1 < y2) ? y1 : y2;
  assign fr1 = (y1 < y2) ? y2 : y1;

  // pixel to block position
  assign xsub = item.x - SCROLL_BIAS;
  assign ysub = item.y - SCROLL_BIAS;
  assign scol = xsub[COORD_W+3:4] & wm;
  assign srow = ysub[COORD_W+3:4] & hm;

  // direction: one step forward, or more than one step back
  assign adv_c = (scol_r > oc_r) ? ((scol_r - oc_r) == COORD_W'(1))
                                 : ((scol_r < oc_r) && ((oc_r - scol_r) > COORD_W'(1)));
  assign adv_r = (srow_r > or_r) ? ((srow_r - or_r) == COORD_W'(1))
                                 : ((srow_r < or_r) && ((or_r - srow_r) > COORD_W'(1)));
  assign col_edge = (adv_c ? COORD_W'(scol_r + COORD_W'(VIEW_COLS - 1)) : scol_r) & wm;
  assign row_edge = (adv_r ? COORD_W'(srow_r + COORD_W'(VIEW_ROWS - 1)) : srow_r) & hm;

  // item fields and cell cursor
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      px_r   <= item.x;
      py_r   <= item.y;
      val_r  <= item.value;
      c0_r   <= fc0;
      c1_r   <= fc1;
      r1_r   <= fr1;
      scol_r <= scol;
      srow_r <= srow;
      if (tmss_cmd_t'(item.cmd) == CMD_FILL) begin
        c_r <= fc0;
        r_r <= fr0;
      end else begin
        c_r <= item.x[COORD_W-1:0];
        r_r <= item.y[COORD_W-1:0];
      end
    end else if (ctl.fill_step) begin
      if (c_r == c1_r) begin
        c_r <= c0_r;
        r_r <= COORD_W'(r_r + COORD_W'(1));
      end else begin
        c_r <= COORD_W'(c_r + COORD_W'(1));
      end
    end else if (ctl.col_setup) begin
      c_r   <= col_edge;
      r_r   <= srow_r;
      cnt_r <= '0;
    end else if (ctl.row_setup) begin
      c_r   <= scol_r;
      r_r   <= row_edge;
      cnt_r <= '0;
    end else if (ctl.col_step) begin
      r_r   <= COORD_W'(r_r + COORD_W'(1)) & hm;
      cnt_r <= CNT_W'(cnt_r + CNT_W'(1));
    end else if (ctl.row_step) begin
      c_r   <= COORD_W'(c_r + COORD_W'(1)) & wm;
      cnt_r <= CNT_W'(cnt_r + CNT_W'(1));
    end
  end

  // previous scroll position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oc_r <= '0;
      or_r <= '0;
    end else if (ctl.commit) begin
      oc_r <= scol_r;
      or_r <= srow_r;
    end
  end

  // row-major address with a stride of the map width
  assign addr = (ADDR_W'(r_r & hm) << wl_r) | ADDR_W'(c_r & wm);

  tmss_ram #(
    .WIDTH (TILE_W),
    .DEPTH (STORE_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ctl.mem_we),
    .re    (ctl.mem_re),
    .addr  (addr),
    .wdata (val_r),
    .rdata (rdata)
  );

  // result fields by kind
  always_comb begin
    res_nxt      = '0;
    res_nxt.kind = ctl.out_kind;
    res_nxt.last = ctl.out_last;
    unique case (ctl.out_kind)
      KIND_DRAW: begin
        res_nxt.screen_col = c_r[SCR_W-1:0];
        res_nxt.screen_row = r_r[SCR_W-1:0];
        res_nxt.tile       = rdata;
      end
      KIND_READ: res_nxt.tile = rdata;
      KIND_SREG: begin
        res_nxt.hscroll = PIX_W'(16'd0 - px_r);
        res_nxt.vscroll = py_r;
      end
      default: res_nxt.tile = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

  // status back to the sequencer
  assign sts.col_chg  = (scol_r != oc_r);
  assign sts.row_chg  = (srow_r != or_r);
  assign sts.fill_end = (c_r == c1_r) && (r_r == r1_r);
  assign sts.col_end  = (cnt_r == CNT_W'(VIEW_ROWS - 1));
  assign sts.row_end  = (cnt_r == CNT_W'(VIEW_COLS - 1));
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

// ===== hdl/tile_map_store_scroll_refresh.sv =====
// channel      | dir | payload
// in_ch        | in  | cmd, x, y, x_other, y_other, value
// out_ch       | out | kind, screen_col, screen_row, tile, hscroll, vscroll, last
// cfg_*        | in  | write enable, register index, 3-bit data
//
// set writes the map store and reports done; read reports the stored tile;
// fill writes the rectangle cell by cell; scroll reports the exposed column,
// then exposed row, then scroll registers; single store port, registered read.
// a finished result waits in the result register while the next item enters.
// reset (rst_n low, synchronous) clears control and scroll position; the map
// store is not cleared. an output stall holds the sequencer in place.
// top level; depends on tmss_pkg, tmss_if, tmss_ctrl, tmss_dp, assert_macros.svh
`include "assert_macros.svh"

module tile_map_store_scroll_refresh import tmss_pkg::*; #(
  parameter int VIEW_COLS = VIEW_COLS_DEF,
  parameter int VIEW_ROWS = VIEW_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tmss_in_if.sink              in_ch,
  tmss_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LOG_W-1:0]     cfg_data
);

  tmss_ctl_t    ctl;
  tmss_sts_t    sts;
  tmss_item_t   item;
  tmss_result_t result;

  // input item payload
  assign item.cmd     = in_ch.cmd;
  assign item.x       = in_ch.x;
  assign item.y       = in_ch.y;
  assign item.x_other = in_ch.x_other;
  assign item.y_other = in_ch.y_other;
  assign item.value   = in_ch.value;

  tmss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  tmss_dp #(
    .VIEW_COLS (VIEW_COLS),
    .VIEW_ROWS (VIEW_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .ctl       (ctl),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .result    (result)
  );

  // result payload
  assign out_ch.kind       = result.kind;
  assign out_ch.screen_col = result.screen_col;
  assign out_ch.screen_row = result.screen_row;
  assign out_ch.tile       = result.tile;
  assign out_ch.hscroll    = result.hscroll;
  assign out_ch.vscroll    = result.vscroll;
  assign out_ch.last       = result.last;

  // checks
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ASSERT_IMPLIES(a_one_mem_access, clk, rst_n, ctl.mem_we, !ctl.mem_re)
  `ASSERT_IMPLIES(a_draw_not_last, clk, rst_n, out_ch.valid && out_ch.kind == KIND_DRAW, !out_ch.last)
  `ASSERT_NEXT(a_load_shows, clk, rst_n, ctl.out_load, out_ch.valid)

endmodule

// ===== test/tile_map_store_scroll_refresh_tb.sv =====
`timescale 1ns / 1ps
// testbench for the tile map store with scroll refresh: directed and random items
// checked against an in-bench predictor; depends on tmss_pkg, tmss_if and the rtl
module tile_map_store_scroll_refresh_tb import tmss_pkg::*; ();

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_ITEMS   = 50;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LOG_W-1:0] cfg_data;

  tmss_in_if  item_bus ();
  tmss_out_if result_bus ();

  tile_map_store_scroll_refresh DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (item_bus),
    .out_ch    (result_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [TILE_W-1:0]  map_cells [STORE_DEPTH];
  logic [COORD_W-1:0] scroll_col;
  logic [COORD_W-1:0] scroll_row;
  logic [LOG_W-1:0]   width_log2;
  logic [LOG_W-1:0]   height_log2;
  tmss_result_t       map_results [$];

  int mismatches;
  int cycle_count;
  int send_idle_pct;
  int stall_pct;
  logic [PIX_W-1:0] pix_x;
  logic [PIX_W-1:0] pix_y;
  tmss_result_t want_res;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int unsigned cell_at(int unsigned c, int unsigned r);
    int unsigned cm;
    int unsigned rm;
    cm = (1 << width_log2) - 1;
    rm = (1 << height_log2) - 1;
    return ((r & rm) << width_log2) | (c & cm);
  endfunction

  function automatic void push_result(tmss_kind_t kind, int unsigned sc, int unsigned sr,
                                      int unsigned tile, int unsigned hs, int unsigned vs,
                                      bit last);
    tmss_result_t res;
    res.kind       = kind;
    res.screen_col = sc[SCR_W-1:0];
    res.screen_row = sr[SCR_W-1:0];
    res.tile       = tile[TILE_W-1:0];
    res.hscroll    = hs[PIX_W-1:0];
    res.vscroll    = vs[PIX_W-1:0];
    res.last       = last;
    map_results.push_back(res);
  endfunction

  function automatic void push_draw(int unsigned c, int unsigned r);
    push_result(KIND_DRAW, c, r, map_cells[cell_at(c, r)], 0, 0, 1'b0);
  endfunction

  // right or bottom edge: one step on, or a backward jump of more than one
  function automatic bit steps_forward(int unsigned now, int unsigned prev);
    return (now > prev && now - prev < 2) || (now < prev && prev - now > 1);
  endfunction

  // work out the results of one accepted item and update the map copy
  function automatic void apply_map_cmd(tmss_item_t it);
    int unsigned wm;
    int unsigned hm;
    int unsigned x1, x2, y1, y2, c0, c1, r0, r1;
    int unsigned col, row, c, r;
    logic [PIX_W-1:0] d;
    wm = (1 << width_log2) - 1;
    hm = (1 << height_log2) - 1;
    case (tmss_cmd_t'(it.cmd))
      CMD_SET: begin
        map_cells[cell_at(it.x, it.y)] = it.value;
        push_result(KIND_DONE, 0, 0, 0, 0, 0, 1'b1);
      end
      CMD_READ: begin
        push_result(KIND_READ, 0, 0, map_cells[cell_at(it.x, it.y)], 0, 0, 1'b1);
      end
      CMD_FILL: begin
        x1 = it.x & wm;
        x2 = it.x_other & wm;
        y1 = it.y & hm;
        y2 = it.y_other & hm;
        c0 = (x1 < x2) ? x1 : x2;
        c1 = (x1 < x2) ? x2 : x1;
        r0 = (y1 < y2) ? y1 : y2;
        r1 = (y1 < y2) ? y2 : y1;
        for (r = r0; r <= r1; r++)
          for (c = c0; c <= c1; c++)
            map_cells[cell_at(c, r)] = it.value;
        push_result(KIND_DONE, 0, 0, 0, 0, 0, 1'b1);
      end
      default: begin
        d   = it.x - SCROLL_BIAS;
        col = (d >> 4) & wm;
        d   = it.y - SCROLL_BIAS;
        row = (d >> 4) & hm;
        // exposed column first
        if (col != scroll_col) begin
          c = (steps_forward(col, scroll_col) ? col + VIEW_COLS_DEF - 1 : col) & wm;
          r = row;
          for (int i = 0; i < VIEW_ROWS_DEF; i++) begin
            push_draw(c, r);
            r = (r + 1) & hm;
          end
        end
        // then exposed row
        if (row != scroll_row) begin
          r = (steps_forward(row, scroll_row) ? row + VIEW_ROWS_DEF - 1 : row) & hm;
          c = col;
          for (int i = 0; i < VIEW_COLS_DEF; i++) begin
            push_draw(c, r);
            c = (c + 1) & wm;
          end
        end
        push_result(KIND_SREG, 0, 0, 0, 16'd0 - it.x, it.y, 1'b1);
        scroll_col = col[COORD_W-1:0];
        scroll_row = row[COORD_W-1:0];
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [PIX_W-1:0] want,
                                      logic [PIX_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (map_results.size() == 0) begin
        $error("unexpected result: kind %0d tile %0h", result_bus.kind, result_bus.tile);
        mismatches++;
      end else begin
        want_res = map_results.pop_front();
        check_field("kind", want_res.kind, result_bus.kind);
        check_field("screen_col", want_res.screen_col, result_bus.screen_col);
        check_field("screen_row", want_res.screen_row, result_bus.screen_row);
        check_field("tile", want_res.tile, result_bus.tile);
        check_field("hscroll", want_res.hscroll, result_bus.hscroll);
        check_field("vscroll", want_res.vscroll, result_bus.vscroll);
        check_field("last", want_res.last, result_bus.last);
      end
    end
  end

  function automatic tmss_item_t make_item(tmss_cmd_t cmd, logic [PIX_W-1:0] x,
                                           logic [PIX_W-1:0] y, logic [COORD_W-1:0] xo,
                                           logic [COORD_W-1:0] yo, logic [TILE_W-1:0] v);
    tmss_item_t it;
    it.cmd     = cmd;
    it.x       = x;
    it.y       = y;
    it.x_other = xo;
    it.y_other = yo;
    it.value   = v;
    return it;
  endfunction

  // send one item, with random idle cycles ahead of it
  task automatic send_item(tmss_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(negedge clk);
    end
    item_bus.valid   <= 1'b1;
    item_bus.cmd     <= it.cmd;
    item_bus.x       <= it.x;
    item_bus.y       <= it.y;
    item_bus.x_other <= it.x_other;
    item_bus.y_other <= it.y_other;
    item_bus.value   <= it.value;
    do @(posedge clk); while (!item_bus.ready);
    apply_map_cmd(it);
  endtask

  // stop sending, wait for every expected result, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (map_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(tmss_reg_t idx, logic [LOG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH_LOG2) width_log2 = data;
    else height_log2 = data;
  endtask

  task automatic set_map_size(logic [LOG_W-1:0] w, logic [LOG_W-1:0] h);
    wait_drained();
    write_reg(REG_WIDTH_LOG2, w);
    write_reg(REG_HEIGHT_LOG2, h);
  endtask

  // set, read and fill at the field extremes; the first fill covers the whole map
  task automatic test_map_access();
    send_item(make_item(CMD_FILL, 16'hFFFF, 16'hFFFF, 7'd0, 7'd0, 8'h5A));
    send_item(make_item(CMD_SET, 16'h0000, 16'h0000, 7'd0, 7'd0, 8'h00));
    send_item(make_item(CMD_SET, 16'hFFFF, 16'hFFFF, 7'd127, 7'd127, 8'hFF));
    send_item(make_item(CMD_SET, 16'h0080, 16'h0100, 7'd0, 7'd0, 8'h81));
    send_item(make_item(CMD_SET, 16'd127, 16'd0, 7'd0, 7'd0, 8'h7E));
    send_item(make_item(CMD_READ, 16'h0000, 16'h0000, 7'd0, 7'd0, 8'h00));
    send_item(make_item(CMD_READ, 16'd127, 16'd127, 7'd0, 7'd0, 8'h00));
    send_item(make_item(CMD_READ, 16'hFF7F, 16'h0000, 7'd127, 7'd127, 8'hFF));
    send_item(make_item(CMD_FILL, 16'd10, 16'd20, 7'd10, 7'd20, 8'hC3));
    send_item(make_item(CMD_FILL, 16'd40, 16'd30, 7'd35, 7'd25, 8'h96));
    send_item(make_item(CMD_READ, 16'd37, 16'd27, 7'd0, 7'd0, 8'h00));
    send_item(make_item(CMD_READ, 16'd10, 16'd20, 7'd0, 7'd0, 8'h00));
    wait_drained();
  endtask

  // no move, wrap back, wrap forward, single steps, jumps and a two-step move
  task automatic test_scroll_edges();
    send_item(make_item(CMD_SCROLL, 16'd16, 16'd16, 7'd0, 7'd0, 8'h00));
    send_item(make_item(CMD_SCROLL, 16'd0, 16'd16, 7'd0, 7'd0, 8'h00));
    send_item(make_item(CMD_SCROLL, 16'd32, 16'd16, 7'd0, 7'd0, 8'h00));
    send_item(make_item(CMD_SCROLL, 16'd48, 16'd32, 7'd0, 7'd0, 8'h00));
    send_item(make_item(CMD_SCROLL, 16'd32, 16'd16, 7'd0, 7'd0, 8'h00));
    send_item(make_item(CMD_SCROLL, 16'hFFFF, 16'hFFFF, 7'd0, 7'd0, 8'h00));
    send_item(make_item(CMD_SCROLL, 16'h8010, 16'h0030, 7'd0, 7'd0, 8'h00));
    send_item(make_item(CMD_SCROLL, 16'd48, 16'h0030, 7'd0, 7'd0, 8'h00));
    wait_drained();
  endtask

  // smallest map, then a one-row map; stored position is compared unmasked
  task automatic test_map_sizes();
    set_map_size(3'd0, 3'd0);
    send_item(make_item(CMD_SET, 16'd5, 16'd9, 7'd0, 7'd0, 8'h3C));
    send_item(make_item(CMD_READ, 16'hFFFF, 16'd0, 7'd0, 7'd0, 8'h00));
    send_item(make_item(CMD_SCROLL, 16'h1234, 16'h4321, 7'd0, 7'd0, 8'h00));
    set_map_size(3'd7, 3'd0);
    send_item(make_item(CMD_SCROLL, 16'hFFFF, 16'd0, 7'd0, 7'd0, 8'h00));
    send_item(make_item(CMD_FILL, 16'd3, 16'd77, 7'd120, 7'd5, 8'hE1));
    send_item(make_item(CMD_READ, 16'd60, 16'd1234, 7'd0, 7'd0, 8'h00));
    wait_drained();
  endtask

  // random sets, reads, fills and scroll moves; most fills and scroll moves are small
  task automatic run_random_items(int count, bit pause_midway);
    tmss_item_t it;
    logic [PIX_W-1:0] rx, ry;
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) wait_drained();
      rx = 16'($urandom);
      ry = 16'($urandom);
      case ($urandom_range(19))
        0, 1, 2, 3, 4: it = make_item(CMD_SET, rx, ry, 7'($urandom), 7'($urandom),
                                      8'($urandom));
        5, 6, 7, 8: it = make_item(CMD_READ, rx, ry, 7'($urandom), 7'($urandom),
                                   8'($urandom));
        9: it = make_item(CMD_FILL, rx, ry, 7'($urandom), 7'($urandom), 8'($urandom));
        10, 11: it = make_item(CMD_FILL, rx, ry, rx[6:0] + 7'($urandom_range(6)),
                               ry[6:0] + 7'($urandom_range(6)), 8'($urandom));
        default: begin
          if ($urandom_range(9) < 2) begin
            pix_x = rx;
            pix_y = ry;
          end else begin
            pix_x = pix_x + 16'($urandom_range(32)) - 16'd16;
            if ($urandom_range(1)) pix_y = pix_y + 16'($urandom_range(32)) - 16'd16;
          end
          it = make_item(CMD_SCROLL, pix_x, pix_y, 7'($urandom), 7'($urandom),
                         8'($urandom));
        end
      endcase
      send_item(it);
    end
    wait_drained();
  endtask

  // random traffic over several map sizes and idle patterns
  task automatic test_random_traffic();
    send_idle_pct = 0;
    stall_pct     = 0;
    set_map_size(3'd7, 3'd7);
    run_random_items(PHASE_ITEMS, 1'b0);
    send_idle_pct = 49;
    set_map_size(3'd3, 3'd5);
    run_random_items(PHASE_ITEMS, 1'b1);
    send_idle_pct = 0;
    stall_pct     = 49;
    set_map_size(3'd0, 3'd7);
    run_random_items(PHASE_ITEMS, 1'b0);
    send_idle_pct = 30;
    stall_pct     = 30;
    set_map_size(3'd4, 3'd1);
    run_random_items(PHASE_ITEMS, 1'b0);
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_WIDTH_LOG2;
    cfg_data         = '0;
    item_bus.valid   = 1'b0;
    item_bus.cmd     = CMD_SET;
    item_bus.x       = '0;
    item_bus.y       = '0;
    item_bus.x_other = '0;
    item_bus.y_other = '0;
    item_bus.value   = '0;
    result_bus.ready = 1'b1;
    mismatches       = 0;
    cycle_count      = 0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    pix_x            = 16'd16;
    pix_y            = 16'd16;
    scroll_col       = '0;
    scroll_row       = '0;
    width_log2       = LOG_RESET;
    height_log2      = LOG_RESET;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_map_access();
    test_scroll_edges();
    test_map_sizes();
    test_random_traffic();

    if (map_results.size() != 0) begin
      $error("%0d expected results never arrived", map_results.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
